>>> src/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/lavm_pkg.sv
// Shared widths, types and helpers for the look-at matrix block.
// No dependencies.
`timescale 1ns / 1ps

package lavm_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int DIFF_W      = WORD_W + 1;
    localparam int FWD_W       = FRAC_BITS + 2;     // holds +/- 1.0
    localparam int PROD_W      = WORD_W + FWD_W;
    localparam int CR_W        = PROD_W + 1;
    localparam int MAG_W       = CR_W;
    localparam int RED_W       = 30;                // reduced magnitude width
    localparam int SUM_W       = 2 * RED_W + 2;
    localparam int ROOT_W      = RED_W + 1;
    localparam int NUM_W       = ROOT_W + FRAC_BITS;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int QCNT_W      = $clog2(QUO_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [WORD_W-1:0] ONE_WORD = WORD_W'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        ROW_RIGHT = 2'd0,
        ROW_Y     = 2'd1,
        ROW_FWD   = 2'd2,
        ROW_EYE   = 2'd3
    } row_t;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] eye;
        logic [2:0][DIFF_W-1:0] diff;
        logic [2:0][WORD_W-1:0] up;
        logic                   diff_zero;
    } item_t;

    typedef struct packed {
        logic                 start;
        logic [2:0][CR_W-1:0] vec;
    } norm_req_t;

    typedef struct packed {
        logic                  done;
        logic                  zero;
        logic [2:0][FWD_W-1:0] comp;
    } norm_res_t;

    function automatic logic [WORD_W-1:0] sat_word(input logic signed [CR_W-1:0] v);
        logic signed [CR_W-1:0] hi;
        logic signed [CR_W-1:0] lo;
        logic [WORD_W-1:0]      r;
        hi = CR_W'({1'b0, {(WORD_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            r = hi[WORD_W-1:0];
        else if (v < lo)
            r = lo[WORD_W-1:0];
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

>>> src/lavm_front.sv
// Front end: takes a command word, forms eye - target, flags eye == target.
// Depends on lavm_pkg.
`timescale 1ns / 1ps

module lavm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lavm_pkg::WORD_W-1:0]   eye_x,
    input  logic [lavm_pkg::WORD_W-1:0]   eye_y,
    input  logic [lavm_pkg::WORD_W-1:0]   eye_z,
    input  logic [lavm_pkg::WORD_W-1:0]   target_x,
    input  logic [lavm_pkg::WORD_W-1:0]   target_y,
    input  logic [lavm_pkg::WORD_W-1:0]   target_z,
    input  logic [lavm_pkg::WORD_W-1:0]   up_x,
    input  logic [lavm_pkg::WORD_W-1:0]   up_y,
    input  logic [lavm_pkg::WORD_W-1:0]   up_z,
    input  logic                          full,
    output logic                          push,
    output lavm_pkg::item_t               item
);
    import lavm_pkg::*;

    item_t item_reg;
    item_t item_next;
    logic  valid_reg;
    logic  valid_next;
    logic  accept;

    assign busy   = valid_reg & full;
    assign accept = start & ~busy;
    assign push   = valid_reg & ~full;
    assign item   = item_reg;

    always_comb
    begin
        item_next         = item_reg;
        item_next.eye     = {eye_z, eye_y, eye_x};
        item_next.up      = {up_z, up_y, up_x};
        item_next.diff[0] = {eye_x[WORD_W-1], eye_x} - {target_x[WORD_W-1], target_x};
        item_next.diff[1] = {eye_y[WORD_W-1], eye_y} - {target_y[WORD_W-1], target_y};
        item_next.diff[2] = {eye_z[WORD_W-1], eye_z} - {target_z[WORD_W-1], target_z};
        item_next.diff_zero = (eye_x == target_x) && (eye_y == target_y)
                              && (eye_z == target_z);
        if (!accept)
            item_next = item_reg;
        valid_next = accept | (valid_reg & full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

>>> src/lavm_queue.sv
// Short queue of classified words between front and back end.
// Depends on lavm_pkg.
`timescale 1ns / 1ps

module lavm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lavm_pkg::item_t din,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output lavm_pkg::item_t head
);
    import lavm_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

>>> src/lavm_norm.sv
// Shared normalise unit: range reduction, sum of squares, bit-serial
// square root and three restoring divisions. Depends on lavm_pkg.
`timescale 1ns / 1ps

module lavm_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  lavm_pkg::norm_req_t req,
    output lavm_pkg::norm_res_t res
);
    import lavm_pkg::*;

    typedef enum logic [3:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_ACC,
        N_ROOT,
        N_LEN,
        N_LOAD,
        N_DIVIDE,
        N_STORE
    } nstate_t;

    nstate_t               state_reg;
    logic                  done_reg;
    logic                  zero_reg;
    logic [2:0][FWD_W-1:0] comp_out_reg;
    logic [2:0]            neg_reg;
    logic [2:0][MAG_W-1:0] mag_reg;
    logic [1:0]            sq_idx_reg;
    logic [2*RED_W-1:0]    prod_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      root_reg;
    logic [SUM_W-1:0]      bit_reg;
    logic [ROOT_W-1:0]     len_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [NUM_W-1:0]      dvs_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [QCNT_W-1:0]     qcnt_reg;
    logic [1:0]            comp_reg;

    logic                  any_high;
    logic [SUM_W:0]        root_trial;
    logic                  root_take;
    logic                  div_take;
    logic [RED_W-1:0]      sq_mag;
    logic [NUM_W-1:0]      num_cur;
    logic [FWD_W-1:0]      quo_ext;

    assign res.done = done_reg;
    assign res.zero = zero_reg;
    assign res.comp = comp_out_reg;

    always_comb
    begin
        any_high = 1'b0;
        for (int i = 0; i < 3; i++)
            any_high = any_high | (|mag_reg[i][MAG_W-1:RED_W]);
        root_trial = {1'b0, root_reg} + {1'b0, bit_reg};
        root_take  = ({1'b0, sum_reg} >= root_trial);
        div_take   = (rem_reg >= dvs_reg);
        sq_mag     = mag_reg[sq_idx_reg][RED_W-1:0];
        num_cur    = (NUM_W'(mag_reg[comp_reg][RED_W-1:0]) << FRAC_BITS)
                     + NUM_W'(len_reg >> 1);
        quo_ext    = FWD_W'(quo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (req.start)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            neg_reg[i] <= req.vec[i][CR_W-1];
                            mag_reg[i] <= req.vec[i][CR_W-1] ? (~req.vec[i] + CR_W'(1))
                                                             : req.vec[i];
                        end
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    // one bit a cycle until every magnitude is below 2^30
                    if (any_high)
                    begin
                        for (int i = 0; i < 3; i++)
                            mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else
                    begin
                        sq_idx_reg <= 2'd0;
                        sum_reg    <= '0;
                        state_reg  <= N_SQUARE;
                    end
                end
                N_SQUARE:
                begin
                    prod_reg <= sq_mag * sq_mag;
                    if (sq_idx_reg != 2'd0)
                        sum_reg <= sum_reg + SUM_W'(prod_reg);
                    if (sq_idx_reg == 2'd2)
                        state_reg <= N_ACC;
                    else
                        sq_idx_reg <= sq_idx_reg + 2'd1;
                end
                N_ACC:
                begin
                    sum_reg   <= sum_reg + SUM_W'(prod_reg);
                    root_reg  <= '0;
                    bit_reg   <= SUM_W'(1) << (SUM_W - 2);
                    state_reg <= N_ROOT;
                end
                N_ROOT:
                begin
                    if (root_take)
                    begin
                        sum_reg  <= sum_reg - root_trial[SUM_W-1:0];
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                        state_reg <= N_LEN;
                end
                N_LEN:
                begin
                    if (root_reg == '0)
                    begin
                        comp_out_reg <= '0;
                        zero_reg     <= 1'b1;
                        done_reg     <= 1'b1;
                        state_reg    <= N_IDLE;
                    end
                    else
                    begin
                        len_reg   <= root_reg[ROOT_W-1:0];
                        comp_reg  <= 2'd0;
                        state_reg <= N_LOAD;
                    end
                end
                N_LOAD:
                begin
                    rem_reg   <= num_cur;
                    dvs_reg   <= NUM_W'(len_reg) << FRAC_BITS;
                    qcnt_reg  <= '0;
                    state_reg <= N_DIVIDE;
                end
                N_DIVIDE:
                begin
                    if (div_take)
                        rem_reg <= rem_reg - dvs_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], div_take};
                    dvs_reg <= dvs_reg >> 1;
                    if (qcnt_reg == QCNT_W'(FRAC_BITS))
                        state_reg <= N_STORE;
                    else
                        qcnt_reg <= qcnt_reg + 1'b1;
                end
                N_STORE:
                begin
                    comp_out_reg[comp_reg] <= neg_reg[comp_reg] ? (~quo_ext + FWD_W'(1))
                                                                : quo_ext;
                    if (comp_reg == 2'd2)
                    begin
                        zero_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= N_LOAD;
                    end
                end
                default:
                    state_reg <= N_IDLE;
            endcase
        end
    end

endmodule

>>> src/lavm_back.sv
// Back end: sequences forward, cross product, right, y, then sends the
// four row groups. Depends on lavm_pkg and lavm_norm.
`timescale 1ns / 1ps

module lavm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  lavm_pkg::item_t             head,
    output logic                        pop,
    output logic                        strobe,
    output lavm_pkg::row_t              row_index,
    output logic [lavm_pkg::WORD_W-1:0] word_a,
    output logic [lavm_pkg::WORD_W-1:0] word_b,
    output logic [lavm_pkg::WORD_W-1:0] word_c,
    output logic [lavm_pkg::WORD_W-1:0] word_d,
    output logic                        last_group,
    output logic                        degenerate
);
    import lavm_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE,
        B_FWD_START,
        B_FWD_WAIT,
        B_CROSS,
        B_RGT_START,
        B_RGT_WAIT,
        B_YMUL,
        B_YRND,
        B_EMIT
    } bstate_t;

    bstate_t                state_reg;
    item_t                  item_reg;
    logic [2:0][FWD_W-1:0]  fwd_reg;
    logic [2:0][FWD_W-1:0]  rgt_reg;
    logic [2:0][WORD_W-1:0] y_reg;
    logic [2:0][CR_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2:0]             step_reg;
    logic                   degen_reg;
    row_t                   row_reg;
    logic                   strobe_reg;
    row_t                   row_out_reg;
    logic [WORD_W-1:0]      word_a_reg;
    logic [WORD_W-1:0]      word_b_reg;
    logic [WORD_W-1:0]      word_c_reg;
    logic [WORD_W-1:0]      word_d_reg;
    logic                   last_reg;
    logic                   degen_out_reg;

    norm_req_t              nreq;
    norm_res_t              nres;

    logic [2:0]             pj;
    logic [1:0]             acc_j;
    logic                   first_term;
    logic [1:0]             ia;
    logic [1:0]             ib;
    logic signed [FWD_W-1:0]  rgt_sel;
    logic signed [FWD_W-1:0]  op_b;
    logic signed [WORD_W-1:0] op_a;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [CR_W-1:0]   term;
    logic signed [CR_W-1:0]   acc_sel;
    logic signed [CR_W-1:0]   acc_new;
    logic                     neg_phase;

    function automatic logic [WORD_W-1:0] ext_word(input logic signed [FWD_W-1:0] v);
        return WORD_W'(v);
    endfunction

    // shift right by FRAC_BITS, rounding half away from zero
    function automatic logic [CR_W-1:0] round_frac(input logic [CR_W-1:0] v);
        logic [CR_W-1:0] m;
        logic [CR_W-1:0] q;
        m = v[CR_W-1] ? (~v + CR_W'(1)) : v;
        q = (m + (CR_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[CR_W-1] ? (~q + CR_W'(1)) : q;
    endfunction

    lavm_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .res   (nres)
    );

    assign pop        = (state_reg == B_IDLE) && !empty;
    assign strobe     = strobe_reg;
    assign row_index  = row_out_reg;
    assign word_a     = word_a_reg;
    assign word_b     = word_b_reg;
    assign word_c     = word_c_reg;
    assign word_d     = word_d_reg;
    assign last_group = last_reg;
    assign degenerate = degen_out_reg;

    always_comb
    begin
        nreq.start = (state_reg == B_FWD_START) || (state_reg == B_RGT_START);
        for (int i = 0; i < 3; i++)
            nreq.vec[i] = (state_reg == B_RGT_START) ? acc_reg[i]
                                                     : CR_W'($signed(item_reg.diff[i]));
    end

    // one product a step; pair n lands in the accumulator at step n + 1
    always_comb
    begin
        pj         = step_reg - 3'd1;
        acc_j      = pj[2:1];
        first_term = ~pj[0];
        unique case (step_reg)
            3'd0:    begin ia = 2'd1; ib = 2'd2; end
            3'd1:    begin ia = 2'd2; ib = 2'd1; end
            3'd2:    begin ia = 2'd2; ib = 2'd0; end
            3'd3:    begin ia = 2'd0; ib = 2'd2; end
            3'd4:    begin ia = 2'd0; ib = 2'd1; end
            3'd5:    begin ia = 2'd1; ib = 2'd0; end
            default: begin ia = 2'd0; ib = 2'd0; end
        endcase
        neg_phase = (state_reg == B_YMUL);
        rgt_sel   = rgt_reg[ia];
        op_a      = neg_phase ? WORD_W'(rgt_sel) : $signed(item_reg.up[ia]);
        op_b      = fwd_reg[ib];
        prod_next = op_a * op_b;
        term      = CR_W'(prod_reg);
        acc_sel   = acc_reg[acc_j];
        // y = fwd x right is taken as -(right x fwd)
        if (first_term)
            acc_new = neg_phase ? -term : term;
        else
            acc_new = neg_phase ? (acc_sel + term) : (acc_sel - term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            strobe_reg    <= 1'b0;
            row_out_reg   <= ROW_RIGHT;
            word_a_reg    <= '0;
            word_b_reg    <= '0;
            word_c_reg    <= '0;
            word_d_reg    <= '0;
            last_reg      <= 1'b0;
            degen_out_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        item_reg <= head;
                        row_reg  <= ROW_RIGHT;
                        if (head.diff_zero)
                        begin
                            fwd_reg   <= '0;
                            rgt_reg   <= '0;
                            y_reg     <= '0;
                            degen_reg <= 1'b1;
                            state_reg <= B_EMIT;
                        end
                        else
                        begin
                            degen_reg <= 1'b0;
                            state_reg <= B_FWD_START;
                        end
                    end
                end
                B_FWD_START:
                    state_reg <= B_FWD_WAIT;
                B_FWD_WAIT:
                begin
                    if (nres.done)
                    begin
                        fwd_reg   <= nres.comp;
                        degen_reg <= degen_reg | nres.zero;
                        step_reg  <= 3'd0;
                        state_reg <= B_CROSS;
                    end
                end
                B_CROSS,
                B_YMUL:
                begin
                    prod_reg <= prod_next;
                    if (step_reg != 3'd0)
                        acc_reg[acc_j] <= acc_new;
                    if (step_reg == 3'd6)
                        state_reg <= (state_reg == B_CROSS) ? B_RGT_START : B_YRND;
                    else
                        step_reg <= step_reg + 3'd1;
                end
                B_RGT_START:
                    state_reg <= B_RGT_WAIT;
                B_RGT_WAIT:
                begin
                    if (nres.done)
                    begin
                        rgt_reg   <= nres.comp;
                        degen_reg <= degen_reg | nres.zero;
                        step_reg  <= 3'd0;
                        state_reg <= B_YMUL;
                    end
                end
                B_YRND:
                begin
                    for (int i = 0; i < 3; i++)
                        y_reg[i] <= sat_word(round_frac(acc_reg[i]));
                    state_reg <= B_EMIT;
                end
                B_EMIT:
                begin
                    strobe_reg    <= 1'b1;
                    row_out_reg   <= row_reg;
                    degen_out_reg <= degen_reg;
                    last_reg      <= (row_reg == ROW_EYE);
                    unique case (row_reg)
                        ROW_RIGHT:
                        begin
                            word_a_reg <= ext_word(rgt_reg[0]);
                            word_b_reg <= ext_word(rgt_reg[1]);
                            word_c_reg <= ext_word(rgt_reg[2]);
                            word_d_reg <= '0;
                        end
                        ROW_Y:
                        begin
                            word_a_reg <= y_reg[0];
                            word_b_reg <= y_reg[1];
                            word_c_reg <= y_reg[2];
                            word_d_reg <= '0;
                        end
                        ROW_FWD:
                        begin
                            word_a_reg <= ext_word(fwd_reg[0]);
                            word_b_reg <= ext_word(fwd_reg[1]);
                            word_c_reg <= ext_word(fwd_reg[2]);
                            word_d_reg <= '0;
                        end
                        ROW_EYE:
                        begin
                            word_a_reg <= item_reg.eye[0];
                            word_b_reg <= item_reg.eye[1];
                            word_c_reg <= item_reg.eye[2];
                            word_d_reg <= ONE_WORD;
                        end
                    endcase
                    if (row_reg == ROW_EYE)
                        state_reg <= B_IDLE;
                    else
                        row_reg <= row_t'(row_reg + 2'd1);
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

>>> src/look_at_view_matrix.sv
// Top level of the look-at view matrix block.
// Depends on lavm_pkg, lavm_front, lavm_queue, lavm_back.
`timescale 1ns / 1ps

// Usage
// - Command channel: a word (eye, target, up, signed Q16.16) is taken at a
//   rising edge with start high and busy low. busy rises only when the
//   front register and the two-entry queue behind it are all occupied.
// - Result channel: four rows per command (right, y, forward, eye) on
//   consecutive cycles, each marked by strobe for one cycle; last_group
//   marks the eye row and degenerate repeats on all four. The receiver
//   cannot stall, so results are never held back.
// - Timing: each command is worked in the back end through the shared
//   normalise unit, used twice (one bit a cycle of range reduction, a
//   31-step square root, three 17-step divisions). That unit sets the rate;
//   the back end takes the next command only once the rows of the last one
//   are sent. When right has zero length its divisions are skipped.
//   When eye equals target the back end skips the normalise unit and goes
//   straight to sending the rows.
// - Up to three further commands are taken while one is being worked.
// - Reset clears the queue and all control; no command or result survives.
module look_at_view_matrix (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lavm_pkg::WORD_W-1:0] eye_x,
    input  logic [lavm_pkg::WORD_W-1:0] eye_y,
    input  logic [lavm_pkg::WORD_W-1:0] eye_z,
    input  logic [lavm_pkg::WORD_W-1:0] target_x,
    input  logic [lavm_pkg::WORD_W-1:0] target_y,
    input  logic [lavm_pkg::WORD_W-1:0] target_z,
    input  logic [lavm_pkg::WORD_W-1:0] up_x,
    input  logic [lavm_pkg::WORD_W-1:0] up_y,
    input  logic [lavm_pkg::WORD_W-1:0] up_z,
    output logic                        strobe,
    output logic [1:0]                  row_index,
    output logic [lavm_pkg::WORD_W-1:0] word_a,
    output logic [lavm_pkg::WORD_W-1:0] word_b,
    output logic [lavm_pkg::WORD_W-1:0] word_c,
    output logic [lavm_pkg::WORD_W-1:0] word_d,
    output logic                        last_group,
    output logic                        degenerate
);
    import lavm_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    row_t  row_sel;

    assign row_index = row_sel;

    lavm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .eye_x    (eye_x),
        .eye_y    (eye_y),
        .eye_z    (eye_z),
        .target_x (target_x),
        .target_y (target_y),
        .target_z (target_z),
        .up_x     (up_x),
        .up_y     (up_y),
        .up_z     (up_z),
        .full     (full),
        .push     (push),
        .item     (front_item)
    );

    lavm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_item),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .head  (head_item)
    );

    lavm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head_item),
        .pop        (pop),
        .strobe     (strobe),
        .row_index  (row_sel),
        .word_a     (word_a),
        .word_b     (word_b),
        .word_c     (word_c),
        .word_d     (word_d),
        .last_group (last_group),
        .degenerate (degenerate)
    );

endmodule

>>> src/lavm_checker.sv
// Port-level checks on the result channel of the look-at matrix block.
// Depends on lavm_pkg and assert_macros.svh; bound to look_at_view_matrix.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lavm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        strobe,
    input logic [1:0]                  row_index,
    input logic [lavm_pkg::WORD_W-1:0] word_d,
    input logic                        last_group,
    input logic                        degenerate
);
    import lavm_pkg::*;

    `ASSERT_IMPLIES(a_last_on_eye, clk, rst_n, strobe, last_group == (row_index == ROW_EYE))
    `ASSERT_IMPLIES(a_eye_pad, clk, rst_n, strobe && row_index == ROW_EYE, word_d == ONE_WORD)
    `ASSERT_IMPLIES(a_zero_pad, clk, rst_n, strobe && row_index != ROW_EYE, word_d == '0)
    `ASSERT_NEXT(a_rows_follow, clk, rst_n, strobe && row_index != ROW_EYE, strobe)
    `ASSERT_IMPLIES(a_degen_held, clk, rst_n, strobe && row_index != ROW_RIGHT, $past(strobe) && degenerate == $past(degenerate))

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);

>>> tb/sv/look_at_view_matrix_checker.sv
// Result checker for the look-at view matrix block: predicts four rows per command word.
// Depends on lavm_pkg for widths, FRAC_BITS and the row codes.
`timescale 1ns / 1ps

module look_at_view_matrix_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [lavm_pkg::WORD_W-1:0] eye_x,
    input  logic [lavm_pkg::WORD_W-1:0] eye_y,
    input  logic [lavm_pkg::WORD_W-1:0] eye_z,
    input  logic [lavm_pkg::WORD_W-1:0] target_x,
    input  logic [lavm_pkg::WORD_W-1:0] target_y,
    input  logic [lavm_pkg::WORD_W-1:0] target_z,
    input  logic [lavm_pkg::WORD_W-1:0] up_x,
    input  logic [lavm_pkg::WORD_W-1:0] up_y,
    input  logic [lavm_pkg::WORD_W-1:0] up_z,
    input  logic                        strobe,
    input  logic [1:0]                  row_index,
    input  logic [lavm_pkg::WORD_W-1:0] word_a,
    input  logic [lavm_pkg::WORD_W-1:0] word_b,
    input  logic [lavm_pkg::WORD_W-1:0] word_c,
    input  logic [lavm_pkg::WORD_W-1:0] word_d,
    input  logic                        last_group,
    input  logic                        degenerate,
    output int                          errors,
    output int                          rows_pending,
    output int                          rows_seen,
    output int                          degen_seen
);
    import lavm_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        row_t              row;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic              last;
        logic              degen;
    } matrix_row_t;

    matrix_row_t expected_rows[$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit vector by sign/magnitude; true when the length is zero.
    function automatic bit unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned mag [3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        int              s;
        mx  = 0;
        sum = 0;
        s   = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        while ((mx >> s) >= (64'd1 << 30))
            s++;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> s;
            sum    = sum + mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        if (len == 0)
        begin
            for (int i = 0; i < 3; i++)
                u[i] = 0;
            return 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            q    = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic longint round_frac(input longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [WORD_W-1:0] clamp_word(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[WORD_W-1:0];
    endfunction

    task automatic predict_matrix();
        vec3_t       eye, up, diff, fwd, cr, rgt, yv;
        longint      rows [4][4];
        bit          degen;
        matrix_row_t r;
        eye  = '{longint'($signed(eye_x)), longint'($signed(eye_y)), longint'($signed(eye_z))};
        up   = '{longint'($signed(up_x)), longint'($signed(up_y)), longint'($signed(up_z))};
        diff = '{eye[0] - longint'($signed(target_x)),
                 eye[1] - longint'($signed(target_y)),
                 eye[2] - longint'($signed(target_z))};
        degen = unit_vec(diff, fwd);
        cr[0] = up[1] * fwd[2] - up[2] * fwd[1];
        cr[1] = up[2] * fwd[0] - up[0] * fwd[2];
        cr[2] = up[0] * fwd[1] - up[1] * fwd[0];
        if (unit_vec(cr, rgt))
            degen = 1'b1;
        yv[0] = round_frac(fwd[1] * rgt[2] - fwd[2] * rgt[1]);
        yv[1] = round_frac(fwd[2] * rgt[0] - fwd[0] * rgt[2]);
        yv[2] = round_frac(fwd[0] * rgt[1] - fwd[1] * rgt[0]);
        for (int i = 0; i < 3; i++)
        begin
            rows[0][i] = rgt[i];
            rows[1][i] = yv[i];
            rows[2][i] = fwd[i];
            rows[3][i] = eye[i];
        end
        rows[0][3] = 0;
        rows[1][3] = 0;
        rows[2][3] = 0;
        rows[3][3] = longint'(64'd1 << FRAC_BITS);
        for (int k = 0; k < 4; k++)
        begin
            r.row   = row_t'(k);
            r.a     = clamp_word(rows[k][0]);
            r.b     = clamp_word(rows[k][1]);
            r.c     = clamp_word(rows[k][2]);
            r.d     = clamp_word(rows[k][3]);
            r.last  = (r.row == ROW_EYE);
            r.degen = degen;
            expected_rows.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    initial
    begin
        errors       = 0;
        rows_pending = 0;
        rows_seen    = 0;
        degen_seen   = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_matrix();
            if (strobe)
            begin
                if (expected_rows.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected row, expected none, got row %0d", $time,
                             row_index);
                end
                else
                begin
                    matrix_row_t e;
                    e = expected_rows.pop_front();
                    rows_seen++;
                    if (e.degen)
                        degen_seen++;
                    check_field("row_index", WORD_W'(e.row), WORD_W'(row_index));
                    check_field("word_a", e.a, word_a);
                    check_field("word_b", e.b, word_b);
                    check_field("word_c", e.c, word_c);
                    check_field("word_d", e.d, word_d);
                    check_field("last_group", WORD_W'(e.last), WORD_W'(last_group));
                    check_field("degenerate", WORD_W'(e.degen), WORD_W'(degenerate));
                end
            end
            rows_pending = expected_rows.size();
        end
    end

endmodule

>>> tb/sv/look_at_view_matrix_test.sv
// Testbench top for the look-at view matrix block: clock, reset, command words, verdict.
// Depends on lavm_pkg, look_at_view_matrix and look_at_view_matrix_checker.
`timescale 1ns / 1ps

module look_at_view_matrix_test;
    import lavm_pkg::*;

    localparam int RANDOM_WORDS = 460;
    localparam int QUIET_TAIL   = 60;
    localparam int CYCLE_LIMIT  = 1000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [WORD_W-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
    logic [WORD_W-1:0] target_x = '0, target_y = '0, target_z = '0;
    logic [WORD_W-1:0] up_x = '0, up_y = '0, up_z = '0;
    logic              strobe;
    logic [1:0]        row_index;
    logic [WORD_W-1:0] word_a, word_b, word_c, word_d;
    logic              last_group, degenerate;
    int                errors, rows_pending, rows_seen, degen_seen;
    int                words_sent;
    longint            cycles;

    always #4 clk = ~clk;

    look_at_view_matrix u_top (.*);

    look_at_view_matrix_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cycle limit reached");
            $display("look_at_view_matrix verification failed");
            $finish;
        end
    end

    // Drives one command word and holds it until taken; start stays high on return.
    task automatic send_word(input logic [WORD_W-1:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        bit taken;
        start    <= 1'b1;
        eye_x    <= ex;
        eye_y    <= ey;
        eye_z    <= ez;
        target_x <= tx;
        target_y <= ty;
        target_z <= tz;
        up_x     <= ux;
        up_y     <= uy;
        up_z     <= uz;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        words_sent++;
    endtask

    task automatic idle_burst(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return WORD_W'($signed($urandom_range(0, 20)) - 10) << 16;
            2: return WORD_W'($signed($urandom_range(0, 8191)) - 4096);
            3: return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
            default: return WORD_W'($signed($urandom_range(0, 2000000)) - 1000000) << 4;
        endcase
    endfunction

    initial
    begin
        logic [WORD_W-1:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
        int                mode;
        int                kind;
        int                wait_cycles;
        cycles     = 0;
        words_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: typical, degenerate cases, field extremes.
        send_word(0, 0, 32'h00050000, 0, 0, 0, 0, 32'h00010000, 0);
        send_word(32'h00030000, 32'h00020000, 32'h00010000, 32'h00030000, 32'h00020000,
                  32'h00010000, 0, 32'h00010000, 0);
        send_word(32'h00010000, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(0, 32'h00040000, 0, 0, 0, 0, 0, 32'h00020000, 0);
        send_word(0, 32'h00040000, 0, 0, 0, 0, 0, 32'hfffe0000, 0);
        send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_word(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0,
                  32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_word(1, 0, 0, 0, 0, 0, 0, 1, 0);
        send_word(0, 0, 1, 0, 0, 0, 32'h7fffffff, 0, 0);
        send_word(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 0, 32'h80000000);
        send_word(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321, 32'h13579bdf,
                  32'h2468ace0, 32'h55555555, 32'haaaaaaaa, 32'h33333333);
        idle_burst(3);
        send_word(32'haaaaaaaa, 32'h55555555, 32'hcccccccc, 32'h55555555, 32'haaaaaaaa,
                  32'h33333333, 32'haaaaaaaa, 32'h55555555, 32'hcccccccc);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 16));
            mode = $urandom_range(0, 4);
            kind = $urandom_range(0, 9);
            ex = rand_coord(mode);
            ey = rand_coord(mode);
            ez = rand_coord(mode);
            tx = rand_coord(mode);
            ty = rand_coord(mode);
            tz = rand_coord(mode);
            ux = rand_coord(mode);
            uy = rand_coord(mode);
            uz = rand_coord(mode);
            if (kind == 0)
            begin
                // eye on the target
                tx = ex;
                ty = ey;
                tz = ez;
            end
            else if (kind == 1)
            begin
                // up along the view direction
                ux = ex - tx;
                uy = ey - ty;
                uz = ez - tz;
            end
            else if (kind == 2)
            begin
                ux = '0;
                uy = '0;
                uz = '0;
            end
            send_word(ex, ey, ez, tx, ty, tz, ux, uy, uz);
        end
        start <= 1'b0;

        // sample away from the rising edge so the last prediction is counted
        @(negedge clk);
        while (rows_pending != 0)
            @(negedge clk);
        wait_cycles = 20;
        repeat (wait_cycles) @(posedge clk);

        $display("%0d command words, %0d rows checked, %0d rows flagged degenerate",
                 words_sent, rows_seen, degen_seen);
        if (errors == 0)
            $display("look_at_view_matrix verification clean");
        else
            $display("look_at_view_matrix verification failed");
        $finish;
    end

endmodule
